[rtl/core/dque_pkg.sv]
package dque_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = 7;
   localparam int DATA_W   = 32;
   localparam int REQ_W    = 3;
   localparam int STAT_W   = 2;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_DUMP_FWD   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_DUMP_BWD   = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] item;
      logic [STAT_W-1:0]        status;
      logic                     last;
      logic [CNT_W-1:0]         occ;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic [1:0] count;
      logic       pop;
   } outq_stat_type;

   function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
                                                 logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IDX_W+1)'(CAPACITY)) begin
         sum = sum - (IDX_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] ring_dec(logic [IDX_W-1:0] base);
      logic [IDX_W-1:0] res;
      if (base == '0) begin
         res = IDX_W'(CAPACITY - 1);
      end else begin
         res = base - IDX_W'(1);
      end
      return res;
   endfunction

endpackage

[rtl/core/dque_if.sv]
interface dque_req_if;
   logic                                valid;
   logic                                ready;
   logic [dque_pkg::REQ_W-1:0]          req_type;
   logic signed [dque_pkg::DATA_W-1:0]  item_in;

   modport source (output valid, output req_type, output item_in, input ready);
   modport sink   (input valid, input req_type, input item_in, output ready);
endinterface

interface dque_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dque_pkg::DATA_W-1:0]  item_out;
   logic [dque_pkg::STAT_W-1:0]         status;
   logic                                last_flag;
   logic [dque_pkg::CNT_W-1:0]          occupancy_out;

   modport source (output valid, output item_out, output status, output last_flag,
                   output occupancy_out, input ready);
   modport sink   (input valid, input item_out, input status, input last_flag,
                   input occupancy_out, output ready);
endinterface

[rtl/core/dque_ram.sv]
module dque_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/dque_outq.sv]
module dque_outq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  dque_pkg::rsp_type        push_data,
   output dque_pkg::outq_stat_type  stat,
   dque_rsp_if.source               rsp_chan
);

   dque_pkg::rsp_type ent_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              pop;
   dque_pkg::rsp_type head;

   assign head           = ent_ff[rd_ptr_ff];
   assign rsp_chan.valid = (count_ff != 2'd0);
   assign rsp_chan.item_out      = head.item;
   assign rsp_chan.status        = head.status;
   assign rsp_chan.last_flag     = head.last;
   assign rsp_chan.occupancy_out = head.occ;
   assign pop = rsp_chan.valid && rsp_chan.ready;

   assign stat.count = count_ff;
   assign stat.pop   = pop;

   always_comb begin
      wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/dque_ctrl.sv]
module dque_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   dque_req_if.sink                            req_chan,
   input  dque_pkg::outq_stat_type             oq_stat,
   input  logic [dque_pkg::DATA_W-1:0]         ram_rd_data,
   output dque_pkg::ram_req_type               ram_req,
   output logic                                push_valid,
   output dque_pkg::rsp_type                   push_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic                             state_ff, state_in;
   logic [dque_pkg::IDX_W-1:0]       front_ff, front_in;
   logic [dque_pkg::CNT_W-1:0]       occ_ff, occ_in;
   logic [dque_pkg::CNT_W-1:0]       k_ff, k_in;
   logic                             back_ff, back_in;
   logic                             s1_valid_ff, s1_valid_in;
   logic                             s1_ram_ff, s1_ram_in;
   logic [dque_pkg::STAT_W-1:0]      s1_status_ff, s1_status_in;
   logic                             s1_last_ff, s1_last_in;
   logic [dque_pkg::CNT_W-1:0]       s1_occ_ff, s1_occ_in;

   logic                             room;
   logic                             accept;
   logic [dque_pkg::CNT_W-1:0]       occ_m1;
   logic [dque_pkg::CNT_W-1:0]       dump_off;

   // one slot per result either queued or in the read stage
   assign room = ({1'b0, oq_stat.count} + {2'b0, s1_valid_ff}) < (3'd2 + {2'b0, oq_stat.pop});
   assign req_chan.ready = (state_ff == ST_IDLE) && room;
   assign accept = req_chan.valid && req_chan.ready;
   assign occ_m1 = occ_ff - dque_pkg::CNT_W'(1);
   assign dump_off = back_ff ? (occ_m1 - k_ff) : k_ff;

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      occ_in       = occ_ff;
      k_in         = k_ff;
      back_in      = back_ff;
      s1_valid_in  = 1'b0;
      s1_ram_in    = 1'b0;
      s1_status_in = dque_pkg::STAT_OK;
      s1_last_in   = 1'b1;
      s1_occ_in    = occ_ff;
      ram_req      = '0;
      ram_req.wr_data = req_chan.item_in;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.req_type)
                  dque_pkg::REQ_PUSH_FRONT, dque_pkg::REQ_PUSH_BACK: begin
                     s1_valid_in = 1'b1;
                     if (occ_ff >= dque_pkg::CAP_CNT) begin
                        s1_status_in = dque_pkg::STAT_FULL;
                     end else begin
                        ram_req.wr_en = 1'b1;
                        if (req_chan.req_type == dque_pkg::REQ_PUSH_FRONT) begin
                           front_in        = dque_pkg::ring_dec(front_ff);
                           ram_req.wr_addr = dque_pkg::ring_dec(front_ff);
                        end else begin
                           ram_req.wr_addr = dque_pkg::ring_add(front_ff,
                                                occ_ff[dque_pkg::IDX_W-1:0]);
                        end
                        occ_in    = occ_ff + dque_pkg::CNT_W'(1);
                        s1_occ_in = occ_ff + dque_pkg::CNT_W'(1);
                     end
                  end
                  dque_pkg::REQ_POP_FRONT, dque_pkg::REQ_POP_BACK: begin
                     s1_valid_in = 1'b1;
                     if (occ_ff == '0) begin
                        s1_status_in = dque_pkg::STAT_EMPTY;
                     end else begin
                        ram_req.rd_en = 1'b1;
                        s1_ram_in     = 1'b1;
                        if (req_chan.req_type == dque_pkg::REQ_POP_FRONT) begin
                           ram_req.rd_addr = front_ff;
                           front_in = dque_pkg::ring_add(front_ff,
                                                         dque_pkg::IDX_W'(1));
                        end else begin
                           ram_req.rd_addr = dque_pkg::ring_add(front_ff,
                                                occ_m1[dque_pkg::IDX_W-1:0]);
                        end
                        occ_in    = occ_m1;
                        s1_occ_in = occ_m1;
                     end
                  end
                  dque_pkg::REQ_DUMP_FWD, dque_pkg::REQ_DUMP_BWD: begin
                     s1_valid_in = 1'b1;
                     if (occ_ff == '0) begin
                        s1_status_in = dque_pkg::STAT_EMPTY;
                     end else begin
                        ram_req.rd_en = 1'b1;
                        s1_ram_in     = 1'b1;
                        back_in       = (req_chan.req_type == dque_pkg::REQ_DUMP_BWD);
                        if (req_chan.req_type == dque_pkg::REQ_DUMP_BWD) begin
                           ram_req.rd_addr = dque_pkg::ring_add(front_ff,
                                                occ_m1[dque_pkg::IDX_W-1:0]);
                        end else begin
                           ram_req.rd_addr = front_ff;
                        end
                        s1_last_in = (occ_ff == dque_pkg::CNT_W'(1));
                        k_in       = dque_pkg::CNT_W'(1);
                        if (occ_ff != dque_pkg::CNT_W'(1)) begin
                           state_in = ST_DUMP;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (room) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = dque_pkg::ring_add(front_ff,
                                                    dump_off[dque_pkg::IDX_W-1:0]);
               s1_valid_in = 1'b1;
               s1_ram_in   = 1'b1;
               s1_last_in  = (k_ff == occ_m1);
               k_in        = k_ff + dque_pkg::CNT_W'(1);
               if (k_ff == occ_m1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         front_ff    <= '0;
         occ_ff      <= '0;
         k_ff        <= '0;
         back_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         front_ff    <= front_in;
         occ_ff      <= occ_in;
         k_ff        <= k_in;
         back_ff     <= back_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ram_ff    <= s1_ram_in;
      s1_status_ff <= s1_status_in;
      s1_last_ff   <= s1_last_in;
      s1_occ_ff    <= s1_occ_in;
   end

   // read data is registered in the RAM and lands in the cycle after the address
   assign push_valid       = s1_valid_ff;
   assign push_data.item   = s1_ram_ff ? ram_rd_data : '0;
   assign push_data.status = s1_status_ff;
   assign push_data.last   = s1_last_ff;
   assign push_data.occ    = s1_occ_ff;

endmodule

[rtl/core/double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit values held in a ring RAM of
// dque_pkg::CAPACITY entries, with a front index and an occupancy count in
// flip-flops. Every request returns one result beat, except a dump of a
// non-empty queue, which returns one beat per stored value with last_flag on
// the final one; unused request codes are taken and give no result. Pushes and
// pops are taken one per cycle while results drain; each result is registered
// in the read stage, then in the output queue. A dump of N values streams one
// beat per cycle while results drain and holds off the request port until the
// read of its final value is issued. A two-entry output queue lets the next
// request in while a result waits. The RAM needs no clearing after reset.
module double_ended_queue (
   input  logic        clock,
   input  logic        reset,
   dque_req_if.sink    req_chan,
   dque_rsp_if.source  rsp_chan
);

   dque_pkg::ram_req_type              ram_req;
   logic [dque_pkg::DATA_W-1:0]        ram_rd_data;
   dque_pkg::outq_stat_type            oq_stat;
   logic                               push_valid;
   dque_pkg::rsp_type                  push_data;

   dque_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .oq_stat     (oq_stat),
      .ram_rd_data (ram_rd_data),
      .ram_req     (ram_req),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   dque_ram #(
      .WIDTH (dque_pkg::DATA_W),
      .DEPTH (dque_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   dque_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .stat       (oq_stat),
      .rsp_chan   (rsp_chan)
   );

endmodule

[bench/tb_double_ended_queue.sv]
`timescale 1ns / 1ps

module tb_double_ended_queue;

   localparam logic [dque_pkg::REQ_W-1:0] REQ_SPARE_6 = 3'd6;
   localparam logic [dque_pkg::REQ_W-1:0] REQ_SPARE_7 = 3'd7;
   localparam int RAND_ITEMS = 155;
   localparam int QUIET_TAIL = 30;
   localparam int STALL_LIMIT = 2000;
   localparam int DIR_ROWS = 21;

   typedef struct packed {
      logic [dque_pkg::REQ_W-1:0]  op;
      logic [dque_pkg::DATA_W-1:0] val;
      logic                        typed;
      logic [dque_pkg::DATA_W-1:0] e_item;
      logic [dque_pkg::STAT_W-1:0] e_stat;
      logic [dque_pkg::CNT_W-1:0]  e_occ;
   } stim_row_type;

   logic clock;
   logic reset;

   dque_req_if req_if ();
   dque_rsp_if rsp_if ();

   double_ended_queue i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // shadow deque state
   logic [dque_pkg::DATA_W-1:0] shadow_ring [dque_pkg::CAPACITY];
   int shadow_head;
   int shadow_fill;

   dque_pkg::rsp_type step_beats [$];
   dque_pkg::rsp_type pending_beats [$];

   bit gaps_on;
   int mismatch_count;
   int reqs_in;
   int beats_out;
   int full_refused;
   int empty_hits;
   int peak_fill;
   int rand_items;
   int idle_cycles;

   stim_row_type dir_rows [DIR_ROWS] = '{
      '{dque_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000,
        dque_pkg::STAT_EMPTY, 7'd0},
      '{dque_pkg::REQ_POP_BACK,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000,
        dque_pkg::STAT_EMPTY, 7'd0},
      '{dque_pkg::REQ_DUMP_FWD,   32'h0000_0000, 1'b1, 32'h0000_0000,
        dque_pkg::STAT_EMPTY, 7'd0},
      '{dque_pkg::REQ_DUMP_BWD,   32'h0000_0000, 1'b1, 32'h0000_0000,
        dque_pkg::STAT_EMPTY, 7'd0},
      '{dque_pkg::REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd1},
      '{dque_pkg::REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd2},
      '{dque_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd3},
      '{dque_pkg::REQ_PUSH_BACK,  32'h0000_0000, 1'b1, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd4},
      '{dque_pkg::REQ_DUMP_FWD,   32'h0000_0000, 1'b0, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd0},
      '{dque_pkg::REQ_DUMP_BWD,   32'h0000_0000, 1'b0, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd0},
      '{REQ_SPARE_6,              32'h5A5A_5A5A, 1'b0, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd0},
      '{REQ_SPARE_7,              32'hA5A5_A5A5, 1'b0, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd0},
      '{dque_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF,
        dque_pkg::STAT_OK,    7'd3},
      '{dque_pkg::REQ_POP_BACK,   32'h0000_0000, 1'b1, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd2},
      '{dque_pkg::REQ_PUSH_BACK,  32'h1234_5678, 1'b0, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd0},
      '{dque_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b1, 32'h8000_0000,
        dque_pkg::STAT_OK,    7'd2},
      '{dque_pkg::REQ_POP_BACK,   32'h0000_0000, 1'b1, 32'h1234_5678,
        dque_pkg::STAT_OK,    7'd1},
      '{dque_pkg::REQ_POP_BACK,   32'h0000_0000, 1'b1, 32'h7FFF_FFFF,
        dque_pkg::STAT_OK,    7'd0},
      '{dque_pkg::REQ_PUSH_FRONT, 32'h0000_0001, 1'b0, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd0},
      '{dque_pkg::REQ_DUMP_FWD,   32'h0000_0000, 1'b0, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd0},
      '{dque_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0000_0000,
        dque_pkg::STAT_OK,    7'd0}
   };

   always #2 clock = ~clock;

   function automatic void add_beat(logic [dque_pkg::DATA_W-1:0] v,
                                    logic [dque_pkg::STAT_W-1:0] st,
                                    logic fin);
      dque_pkg::rsp_type b;
      b.item   = v;
      b.status = st;
      b.last   = fin;
      b.occ    = dque_pkg::CNT_W'(shadow_fill);
      step_beats.push_back(b);
   endfunction

   function automatic void model_request(logic [dque_pkg::REQ_W-1:0] op,
                                         logic [dque_pkg::DATA_W-1:0] val);
      logic [dque_pkg::DATA_W-1:0] v;
      int off;
      step_beats.delete();
      case (op)
         dque_pkg::REQ_PUSH_FRONT, dque_pkg::REQ_PUSH_BACK: begin
            if (shadow_fill >= dque_pkg::CAPACITY) begin
               add_beat('0, dque_pkg::STAT_FULL, 1'b1);
            end else begin
               if (op == dque_pkg::REQ_PUSH_FRONT) begin
                  shadow_head = (shadow_head + dque_pkg::CAPACITY - 1) % dque_pkg::CAPACITY;
                  shadow_ring[shadow_head] = val;
               end else begin
                  shadow_ring[(shadow_head + shadow_fill) % dque_pkg::CAPACITY] = val;
               end
               shadow_fill++;
               add_beat('0, dque_pkg::STAT_OK, 1'b1);
            end
         end
         dque_pkg::REQ_POP_FRONT, dque_pkg::REQ_POP_BACK: begin
            if (shadow_fill == 0) begin
               add_beat('0, dque_pkg::STAT_EMPTY, 1'b1);
            end else begin
               if (op == dque_pkg::REQ_POP_FRONT) begin
                  v = shadow_ring[shadow_head];
                  shadow_head = (shadow_head + 1) % dque_pkg::CAPACITY;
               end else begin
                  v = shadow_ring[(shadow_head + shadow_fill - 1) % dque_pkg::CAPACITY];
               end
               shadow_fill--;
               add_beat(v, dque_pkg::STAT_OK, 1'b1);
            end
         end
         dque_pkg::REQ_DUMP_FWD, dque_pkg::REQ_DUMP_BWD: begin
            if (shadow_fill == 0) begin
               add_beat('0, dque_pkg::STAT_EMPTY, 1'b1);
            end else begin
               for (int k = 0; k < shadow_fill; k++) begin
                  off = (op == dque_pkg::REQ_DUMP_FWD) ? k : shadow_fill - 1 - k;
                  add_beat(shadow_ring[(shadow_head + off) % dque_pkg::CAPACITY],
                           dque_pkg::STAT_OK, k == shadow_fill - 1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic hold_off(int n);
      @(negedge clock);
      req_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_beat(logic [dque_pkg::REQ_W-1:0] op,
                            logic [dque_pkg::DATA_W-1:0] val, logic typed,
                            dque_pkg::rsp_type want);
      if (gaps_on && $urandom_range(0, 99) < 20) begin
         hold_off($urandom_range(1, 10));
      end
      @(negedge clock);
      req_if.valid    <= 1'b1;
      req_if.req_type <= op;
      req_if.item_in  <= val;
      do @(posedge clock); while (!req_if.ready);
      model_request(op, val);
      if (typed) begin
         pending_beats.push_back(want);
      end else begin
         foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
      end
      reqs_in++;
      if (shadow_fill > peak_fill) peak_fill = shadow_fill;
   endtask

   task automatic send_random(logic [dque_pkg::REQ_W-1:0] op);
      send_beat(op, $urandom, 1'b0, '0);
   endtask

   // result side: random stall bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0 && gaps_on) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (gaps_on && $urandom_range(0, 99) < 15) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(1, 10) - 1;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = 0;
         end
      end
   end

   always @(posedge clock) begin
      dque_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         beats_out++;
         if (pending_beats.size() == 0) begin
            $error("result beat with nothing expected: item_out %0d status %0d",
                   rsp_if.item_out, rsp_if.status);
            mismatch_count++;
         end else begin
            want = pending_beats.pop_front();
            if (want.status == dque_pkg::STAT_FULL) full_refused++;
            if (want.status == dque_pkg::STAT_EMPTY) empty_hits++;
            if (rsp_if.item_out !== want.item) begin
               $error("item_out: expected %0d, got %0d", $signed(want.item),
                      rsp_if.item_out);
               mismatch_count++;
            end
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_if.status);
               mismatch_count++;
            end
            if (rsp_if.last_flag !== want.last) begin
               $error("last_flag: expected %0d, got %0d", want.last, rsp_if.last_flag);
               mismatch_count++;
            end
            if (rsp_if.occupancy_out !== want.occ) begin
               $error("occupancy_out: expected %0d, got %0d", want.occ,
                      rsp_if.occupancy_out);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, pending_beats.size());
         $display("double_ended_queue: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      dque_pkg::rsp_type want;
      int ep_len;
      int push_bias;
      bit ep_gaps;
      int pick;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.req_type = dque_pkg::REQ_PUSH_FRONT;
      req_if.item_in = '0;
      idle_cycles = 0;
      shadow_head = 0;
      shadow_fill = 0;
      gaps_on = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         want.item   = dir_rows[i].e_item;
         want.status = dir_rows[i].e_stat;
         want.last   = 1'b1;
         want.occ    = dir_rows[i].e_occ;
         send_beat(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, want);
      end

      // fill to capacity, overflow, then full-length dumps both ways
      while (shadow_fill < dque_pkg::CAPACITY) begin
         send_random($urandom_range(0, 1) ? dque_pkg::REQ_PUSH_FRONT
                                          : dque_pkg::REQ_PUSH_BACK);
         rand_items++;
      end
      send_random(dque_pkg::REQ_PUSH_FRONT);
      send_random(dque_pkg::REQ_PUSH_BACK);
      send_random(dque_pkg::REQ_DUMP_FWD);
      send_random(dque_pkg::REQ_DUMP_BWD);
      rand_items += 4;

      while (rand_items < RAND_ITEMS) begin
         ep_len    = $urandom_range(10, 30);
         push_bias = $urandom_range(15, 75);
         ep_gaps   = $urandom_range(0, 3) != 0;
         for (int n = 0; n < ep_len && rand_items < RAND_ITEMS; n++) begin
            gaps_on = ep_gaps && (rand_items < RAND_ITEMS - QUIET_TAIL);
            pick = $urandom_range(0, 99);
            if (pick < push_bias) begin
               send_random($urandom_range(0, 1) ? dque_pkg::REQ_PUSH_FRONT
                                                : dque_pkg::REQ_PUSH_BACK);
               rand_items++;
            end else if (pick < 90) begin
               send_random($urandom_range(0, 1) ? dque_pkg::REQ_POP_FRONT
                                                : dque_pkg::REQ_POP_BACK);
               rand_items++;
            end else if (pick < 97) begin
               send_random($urandom_range(0, 1) ? dque_pkg::REQ_DUMP_FWD
                                                : dque_pkg::REQ_DUMP_BWD);
               rand_items++;
            end else begin
               send_random($urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7);
            end
         end
      end
      gaps_on = 1'b0;

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("ran %0d requests (pushes, pops, dumps, unused codes), %0d result beats",
               reqs_in, beats_out);
      $display("saw %0d refused pushes, %0d empty results, peak occupancy %0d",
               full_refused, empty_hits, peak_fill);
      if (mismatch_count == 0 && pending_beats.size() == 0) begin
         $display("double_ended_queue: match");
      end else begin
         $display("double_ended_queue: mismatch");
      end
      $finish;
   end

endmodule
